/* sv/entab_pkg.sv */
// Shared types, constants and the stop search function for the entab block.
// No dependencies; used by entab_core, entab_fifo and space_run_to_tab_entab.
`default_nettype none

package entab_pkg;

    // character codes
    localparam logic [7:0] ChSpace   = 8'd32;
    localparam logic [7:0] ChTab     = 8'd9;
    localparam logic [7:0] ChNewline = 8'd10;

    // column and count limits
    localparam int          LineMax = 255;
    localparam logic [8:0]  ColMax  = 9'd511;
    localparam logic [15:0] CntMax  = 16'hFFFF;

    // configuration register indexes
    localparam logic [1:0] CfgStop0 = 2'd0;
    localparam logic [1:0] CfgStop1 = 2'd1;
    localparam logic [1:0] CfgStop2 = 2'd2;
    localparam logic [1:0] CfgStop3 = 2'd3;

    // stop bitmap reset: a stop every fourth column from 4
    localparam logic [63:0] StopRst0 = 64'h1111111111111110;
    localparam logic [63:0] StopRst1 = 64'h1111111111111111;
    localparam logic [63:0] StopRst2 = 64'h1111111111111111;
    localparam logic [63:0] StopRst3 = 64'h1111111111111111;

    // result queue depth
    localparam int FifoDepth = 8;

    // one result run
    typedef struct packed {
        logic [7:0]  ch;
        logic [15:0] cnt;
        logic        last;
    } t_res;

    // results of one accepted character, written to the queue together
    typedef struct packed {
        logic [1:0]       num;
        t_res [2:0]       res;
    } t_wr;

    // Lowest set bit of a 256-bit vector, as a log tree of eight levels.
    // Returns {found, index}.
    function automatic logic [8:0] find_first(input logic [255:0] vec);
        logic [255:0] vld;
        logic [7:0]   ix [256];
        int           lvl;
        int           j;
        vld = vec;
        for (j = 0; j < 256; j++) begin
            ix[j] = 8'(j);
        end
        for (lvl = 0; lvl < 8; lvl++) begin
            for (j = 0; j < 128; j++) begin
                if (j < (128 >> lvl)) begin
                    ix[j]  = vld[2*j] ? ix[2*j] : ix[2*j+1];
                    vld[j] = vld[2*j] | vld[2*j+1];
                end
            end
        end
        return {vld[0], ix[0]};
    endfunction

endpackage

`default_nettype wire

/* sv/entab_core.sv */
// Entab state: column, pending counts and stop bitmap; builds the runs of one character.
// Depends on entab_pkg.
`default_nettype none

module entab_core #(
    parameter int LineMax = entab_pkg::LineMax
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [63:0]          i_cfg_data,
    input  wire logic                 i_acc,
    input  wire logic [7:0]           i_char,
    output entab_pkg::t_wr            o_wr
);

    logic [255:0] r_map;
    logic [8:0]   r_col;
    logic [15:0]  r_spaces;
    logic [15:0]  r_tabs;

    logic [8:0]   n_col;
    logic [15:0]  n_spaces;
    logic [15:0]  n_tabs;

    logic         stop_cur;
    logic [255:0] cand;
    logic [8:0]   ff;
    logic [8:0]   tab_stop;
    logic [8:0]   base;
    logic [1:0]   k;

    // stop test at the current column
    assign stop_cur = (r_col > 9'(LineMax)) || r_map[r_col[7:0]];

    // candidate stops at or after the column; past the line end all count
    always_comb begin
        for (int i = 0; i < 256; i++) begin
            cand[i] = (r_map[i] || (i > LineMax)) && (9'(i) >= r_col);
        end
    end

    assign ff       = entab_pkg::find_first(cand);
    assign tab_stop = stop_cur ? r_col : (ff[8] ? {1'b0, ff[7:0]} : 9'd256);

    // next state
    always_comb begin
        n_spaces = r_spaces;
        n_tabs   = r_tabs;
        base     = r_col;
        if (i_char == entab_pkg::ChSpace) begin
            if (stop_cur) begin
                n_spaces = '0;
                if (r_tabs != entab_pkg::CntMax) n_tabs = r_tabs + 16'd1;
            end else if (r_spaces != entab_pkg::CntMax) begin
                n_spaces = r_spaces + 16'd1;
            end
        end else begin
            n_spaces = '0;
            n_tabs   = '0;
            if (i_char == entab_pkg::ChNewline) base = '0;
            if (i_char == entab_pkg::ChTab) base = tab_stop;
        end
        n_col = (base != entab_pkg::ColMax) ? base + 9'd1 : base;
    end

    // runs for a non-space character: tabs, spaces (none before a tab), then the character
    always_comb begin
        k    = '0;
        o_wr = '0;
        if (i_char != entab_pkg::ChSpace) begin
            if (r_tabs != '0) begin
                o_wr.res[k] = {entab_pkg::ChTab, r_tabs, 1'b0};
                k = k + 2'd1;
            end
            if (i_char != entab_pkg::ChTab && r_spaces != '0) begin
                o_wr.res[k] = {entab_pkg::ChSpace, r_spaces, 1'b0};
                k = k + 2'd1;
            end
            o_wr.res[k] = {i_char, 16'd1, 1'b1};
            o_wr.num    = k + 2'd1;
        end
    end

    // state and bitmap registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map    <= {entab_pkg::StopRst3, entab_pkg::StopRst2,
                         entab_pkg::StopRst1, entab_pkg::StopRst0};
            r_col    <= 9'd1;
            r_spaces <= '0;
            r_tabs   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    entab_pkg::CfgStop0: r_map[63:0]    <= i_cfg_data;
                    entab_pkg::CfgStop1: r_map[127:64]  <= i_cfg_data;
                    entab_pkg::CfgStop2: r_map[191:128] <= i_cfg_data;
                    entab_pkg::CfgStop3: r_map[255:192] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_acc) begin
                r_col    <= n_col;
                r_spaces <= n_spaces;
                r_tabs   <= n_tabs;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/entab_fifo.sv */
// Result queue: takes up to three runs per transfer in, hands out one per transfer.
// Depends on entab_pkg.
`default_nettype none

module entab_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire entab_pkg::t_wr       i_wr,
    input  wire logic                 i_stall,
    output logic                      o_full,
    output logic                      o_valid,
    output entab_pkg::t_res           o_res
);

    localparam int PtrW = $clog2(entab_pkg::FifoDepth);
    localparam int CntW = $clog2(entab_pkg::FifoDepth + 1);

    entab_pkg::t_res r_mem [entab_pkg::FifoDepth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;

    logic            pop;
    logic [CntW-1:0] n_count;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    // room must remain for a full set of three runs
    assign o_full  = (r_count > CntW'(entab_pkg::FifoDepth - 3));
    assign o_res   = r_mem[r_rd];

    assign n_count = r_count + (i_push ? CntW'(i_wr.num) : '0) - (pop ? CntW'(1) : '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int k = 0; k < 3; k++) begin
                if (k < int'(i_wr.num)) r_mem[r_wr + PtrW'(k)] <= i_wr.res[k];
            end
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PtrW'(i_wr.num);
            if (pop) r_rd <= r_rd + PtrW'(1);
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

/* sv/space_run_to_tab_entab.sv */
// Top level of the entab block: character in, runs of tabs, spaces and characters out.
// Depends on entab_pkg, entab_core and entab_fifo.
//
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_in_char
// result    out        o_valid / i_stall    o_out_char, o_repeat_count, o_last_of_run
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// A character is taken every cycle while the result queue has room for three runs.
// Each character makes zero to three runs; the result port delivers one run a cycle while i_stall is low,
// so the sustained rate is set by that port.
// Runs appear in the cycle after the character's transfer at the earliest.
// Reset is synchronous: column 1, no pending runs, default stops, queue empty.
// A stalled result holds its payload; the input stalls when the queue nears full.
`default_nettype none

module space_run_to_tab_entab #(
    parameter int LineMax = entab_pkg::LineMax
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_char,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_char,
    output logic [15:0]      o_repeat_count,
    output logic             o_last_of_run
);

    logic            acc;
    entab_pkg::t_wr  wr;
    entab_pkg::t_res res;

    assign acc = i_valid && !o_stall;

    // column tracking and run building
    entab_core #(
        .LineMax (LineMax)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc),
        .i_char     (i_in_char),
        .o_wr       (wr)
    );

    // result queue
    entab_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc),
        .i_wr    (wr),
        .i_stall (i_stall),
        .o_full  (o_stall),
        .o_valid (o_valid),
        .o_res   (res)
    );

    assign o_out_char     = res.ch;
    assign o_repeat_count = res.cnt;
    assign o_last_of_run  = res.last;

endmodule

`default_nettype wire
